[design/obp_pkg.sv]
// obp_pkg: shared types, widths and helpers for the ohlc bar builder
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package obp_pkg;

  localparam int INSTRUMENTS = 16;
  localparam int IDX_W       = 4;
  localparam int TIME_W      = 63;
  localparam int PRICE_W     = 32;
  localparam int TVOL_W      = 32;
  localparam int VOL_W       = 48;
  localparam int MINUTE_W    = 28;
  localparam int SEC_W       = 34;
  localparam int DIV_W       = 36;

  localparam logic [DIV_W-1:0] NS_PER_MINUTE = 36'd60000000000;
  localparam logic [VOL_W-1:0] VOL_MAX       = {VOL_W{1'b1}};

  // minute = (t >> 11) / 29296875, by reciprocal multiply and one correction step
  localparam int MIN_SHIFT = 11;
  localparam int XS_W      = TIME_W - MIN_SHIFT;
  localparam int HALF_W    = XS_W / 2;
  localparam int PROD_W    = MINUTE_W + HALF_W;
  localparam int REM_W     = HALF_W;

  localparam logic [REM_W-1:0]    MIN_DIVISOR = REM_W'(NS_PER_MINUTE >> MIN_SHIFT);
  localparam logic [MINUTE_W-1:0] MIN_RECIP   =
    MINUTE_W'((64'd1 << XS_W) / 64'(NS_PER_MINUTE >> MIN_SHIFT));

  typedef struct packed {
    logic                is_flush;
    logic [IDX_W-1:0]    idx;
    logic [MINUTE_W-1:0] minute;
    logic [PRICE_W-1:0]  price;
    logic [TVOL_W-1:0]   vol;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]   instrument;
    logic [SEC_W-1:0]   start_seconds;
    logic [PRICE_W-1:0] open_p;
    logic [PRICE_W-1:0] high_p;
    logic [PRICE_W-1:0] low_p;
    logic [PRICE_W-1:0] close_p;
    logic [VOL_W-1:0]   volume;
    logic               last;
  } bar_t;

  function automatic logic [SEC_W-1:0] minute_to_seconds(input logic [MINUTE_W-1:0] m);
    logic [SEC_W-1:0] ext;
    ext = {{(SEC_W-MINUTE_W){1'b0}}, m};
    return (ext << 6) - (ext << 2);
  endfunction

endpackage

[design/obp_front.sv]
// obp_front: accepts input words, finds the minute of a tick by a
// reciprocal multiply and hands commands to the command queue; uses obp_pkg
`timescale 1ns / 1ps

module obp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_mode,
  input  logic [obp_pkg::IDX_W-1:0]         in_instrument_index,
  input  logic [obp_pkg::TIME_W-1:0]        in_tick_time_ns,
  input  logic [obp_pkg::PRICE_W-1:0]       in_mid_price,
  input  logic [obp_pkg::TVOL_W-1:0]        in_tick_volume,
  output logic                              q_push,
  output obp_pkg::cmd_t                     q_data,
  input  logic                              q_full
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_PUSH = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [obp_pkg::XS_W-1:0]       xs_r, xs_nxt;
  logic [obp_pkg::PROD_W-1:0]     ph_r, ph_nxt;
  logic [obp_pkg::PROD_W-1:0]     pl_r, pl_nxt;
  logic [obp_pkg::MINUTE_W-1:0]   qest_r, qest_nxt;
  logic [obp_pkg::REM_W-1:0]      rem_r, rem_nxt;
  obp_pkg::cmd_t                  item_r, item_nxt;

  logic [obp_pkg::PROD_W-1:0] prod_hi;
  logic [obp_pkg::PROD_W-1:0] prod_lo;
  logic [obp_pkg::PROD_W-1:0] est_sum;
  logic [obp_pkg::REM_W-1:0]  qd_lo;
  logic                       round_up;

  // estimate may be one low; the remainder check fixes it
  assign prod_hi  = obp_pkg::PROD_W'(xs_r[obp_pkg::XS_W-1:obp_pkg::HALF_W])
                  * obp_pkg::PROD_W'(obp_pkg::MIN_RECIP);
  assign prod_lo  = obp_pkg::PROD_W'(xs_r[obp_pkg::HALF_W-1:0])
                  * obp_pkg::PROD_W'(obp_pkg::MIN_RECIP);
  assign est_sum  = ph_r + obp_pkg::PROD_W'(pl_r[obp_pkg::PROD_W-1:obp_pkg::HALF_W]);
  assign qd_lo    = obp_pkg::REM_W'(qest_r) * obp_pkg::MIN_DIVISOR;
  assign round_up = rem_r >= obp_pkg::MIN_DIVISOR;

  assign in_full = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    xs_nxt    = xs_r;
    ph_nxt    = ph_r;
    pl_nxt    = pl_r;
    qest_nxt  = qest_r;
    rem_nxt   = rem_r;
    item_nxt  = item_r;
    q_push    = 1'b0;
    q_data    = item_r;
    q_data.minute = qest_r + obp_pkg::MINUTE_W'(round_up);
    unique case (state_r)
      ST_IDLE: begin
        if (in_push) begin
          item_nxt.is_flush = in_mode;
          item_nxt.idx      = in_instrument_index;
          item_nxt.minute   = '0;
          item_nxt.price    = in_mid_price;
          item_nxt.vol      = in_tick_volume;
          xs_nxt = in_tick_time_ns[obp_pkg::TIME_W-1:obp_pkg::MIN_SHIFT];
          state_nxt = in_mode ? ST_PUSH : ST_MUL;
        end
      end
      ST_MUL: begin
        ph_nxt    = prod_hi;
        pl_nxt    = prod_lo;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        qest_nxt  = est_sum[obp_pkg::PROD_W-1:obp_pkg::HALF_W];
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        rem_nxt   = xs_r[obp_pkg::REM_W-1:0] - qd_lo;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xs_r   <= xs_nxt;
    ph_r   <= ph_nxt;
    pl_r   <= pl_nxt;
    qest_r <= qest_nxt;
    rem_r  <= rem_nxt;
    item_r <= item_nxt;
  end

endmodule

[design/obp_cmdq.sv]
// obp_cmdq: two-word command queue between the front and the back
// uses obp_pkg for the command type
`timescale 1ns / 1ps

module obp_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  obp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output obp_pkg::cmd_t pop_data,
  output logic          empty
);

  obp_pkg::cmd_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/obp_back.sv]
// obp_back: per-instrument bar table, tick update, flush scan and the
// two-word result queue; uses obp_pkg
`timescale 1ns / 1ps

module obp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  obp_pkg::cmd_t                 q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output obp_pkg::bar_t                 out_bar
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                                 state_r, state_nxt;
  logic [obp_pkg::IDX_W-1:0]            ptr_r, ptr_nxt;
  logic [obp_pkg::INSTRUMENTS-1:0]      active_r, active_nxt;

  logic [obp_pkg::MINUTE_W-1:0] minute_mem [obp_pkg::INSTRUMENTS];
  logic [obp_pkg::PRICE_W-1:0]  open_mem   [obp_pkg::INSTRUMENTS];
  logic [obp_pkg::PRICE_W-1:0]  high_mem   [obp_pkg::INSTRUMENTS];
  logic [obp_pkg::PRICE_W-1:0]  low_mem    [obp_pkg::INSTRUMENTS];
  logic [obp_pkg::PRICE_W-1:0]  close_mem  [obp_pkg::INSTRUMENTS];
  logic [obp_pkg::VOL_W-1:0]    vol_mem    [obp_pkg::INSTRUMENTS];

  obp_pkg::bar_t oq_mem [2];
  logic       oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;
  logic       oq_space;
  logic       oq_push;
  logic       oq_pop;
  obp_pkg::bar_t oq_data;

  logic [obp_pkg::IDX_W-1:0]    rd_idx;
  logic                         wr_en;
  logic                         wr_open;
  logic [obp_pkg::PRICE_W-1:0]  wr_high, wr_low;
  logic [obp_pkg::VOL_W-1:0]    wr_vol;
  logic [obp_pkg::VOL_W:0]      vol_sum;
  logic                         hit;
  logic                         higher_any;

  assign oq_space  = oq_cnt_r != 2'd2;
  assign out_empty = oq_cnt_r == 2'd0;
  assign out_bar   = oq_mem[oq_rd_r];
  assign oq_pop    = out_pop && !out_empty;

  assign rd_idx  = (state_r == ST_SCAN) ? ptr_r : q_data.idx;
  assign hit     = active_r[rd_idx] && (minute_mem[rd_idx] == q_data.minute);
  assign vol_sum = {1'b0, vol_mem[rd_idx]}
                 + {{(obp_pkg::VOL_W-obp_pkg::TVOL_W+1){1'b0}}, q_data.vol};

  always_comb begin
    higher_any = 1'b0;
    for (int j = 0; j < obp_pkg::INSTRUMENTS; j++) begin
      if (j > int'(ptr_r) && active_r[j]) begin
        higher_any = 1'b1;
      end
    end
  end

  always_comb begin
    oq_data.instrument    = rd_idx;
    oq_data.start_seconds = obp_pkg::minute_to_seconds(minute_mem[rd_idx]);
    oq_data.open_p        = open_mem[rd_idx];
    oq_data.high_p        = high_mem[rd_idx];
    oq_data.low_p         = low_mem[rd_idx];
    oq_data.close_p       = close_mem[rd_idx];
    oq_data.volume        = vol_mem[rd_idx];
    oq_data.last          = (state_r == ST_SCAN) ? !higher_any : 1'b1;
  end

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    active_nxt = active_r;
    q_pop      = 1'b0;
    oq_push    = 1'b0;
    wr_en      = 1'b0;
    wr_open    = 1'b0;
    wr_high    = high_mem[rd_idx];
    wr_low     = low_mem[rd_idx];
    wr_vol     = vol_sum[obp_pkg::VOL_W] ? obp_pkg::VOL_MAX : vol_sum[obp_pkg::VOL_W-1:0];
    if (q_data.price > high_mem[rd_idx]) begin
      wr_high = q_data.price;
    end
    if (q_data.price < low_mem[rd_idx]) begin
      wr_low = q_data.price;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && oq_space) begin
          q_pop = 1'b1;
          if (q_data.is_flush) begin
            ptr_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            wr_en = 1'b1;
            if (!hit) begin
              wr_open = 1'b1;
              oq_push = active_r[rd_idx];
              active_nxt[rd_idx] = 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (!active_r[ptr_r] || oq_space) begin
          if (active_r[ptr_r]) begin
            oq_push = 1'b1;
            active_nxt[ptr_r] = 1'b0;
          end
          ptr_nxt = ptr_r + 1'b1;
          if (ptr_r == obp_pkg::IDX_W'(obp_pkg::INSTRUMENTS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    oq_cnt_nxt = oq_cnt_r + {1'b0, oq_push} - {1'b0, oq_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ptr_r    <= '0;
      active_r <= '0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      active_r <= active_nxt;
      oq_wr_r  <= oq_wr_r ^ oq_push;
      oq_rd_r  <= oq_rd_r ^ oq_pop;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem[oq_wr_r] <= oq_data;
    end
  end

  // new bar opens with all four prices equal to the mid price
  always_ff @(posedge clk) begin
    if (wr_en) begin
      close_mem[rd_idx] <= q_data.price;
      if (wr_open) begin
        minute_mem[rd_idx] <= q_data.minute;
        open_mem[rd_idx]   <= q_data.price;
        high_mem[rd_idx]   <= q_data.price;
        low_mem[rd_idx]    <= q_data.price;
        vol_mem[rd_idx]    <= {{(obp_pkg::VOL_W-obp_pkg::TVOL_W){1'b0}}, q_data.vol};
      end else begin
        high_mem[rd_idx] <= wr_high;
        low_mem[rd_idx]  <= wr_low;
        vol_mem[rd_idx]  <= wr_vol;
      end
    end
  end

endmodule

[design/tick_to_ohlc_bar_builder.sv]
// channel  | ports                               | word accepted when
// ---------+-------------------------------------+---------------------
// input    | in_push, in_full, in_* fields       | in_push && !in_full
// result   | out_pop, out_empty, out_* fields    | out_pop && !out_empty
//
// a price tick holds the front through the multiply, sum and fix states of
// the reciprocal minute divide until it enters the command queue; a flush
// holds the front until that point only; the back then scans all 16 entries,
// one per cycle save for result-queue stalls, giving at most one bar per cycle
// reset clears the bar valid bits and the queues; nothing else needs clearing
// a full result queue stalls the back; a full command queue stalls the front
// top level of the ohlc bar builder; depends on obp_pkg, obp_front,
// obp_cmdq and obp_back
`timescale 1ns / 1ps

module tick_to_ohlc_bar_builder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_mode,
  input  logic [obp_pkg::IDX_W-1:0]       in_instrument_index,
  input  logic [obp_pkg::TIME_W-1:0]      in_tick_time_ns,
  input  logic [obp_pkg::PRICE_W-1:0]     in_mid_price,
  input  logic [obp_pkg::TVOL_W-1:0]      in_tick_volume,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [obp_pkg::IDX_W-1:0]       out_bar_instrument,
  output logic [obp_pkg::SEC_W-1:0]       out_bar_start_seconds,
  output logic [obp_pkg::PRICE_W-1:0]     out_open_price,
  output logic [obp_pkg::PRICE_W-1:0]     out_high_price,
  output logic [obp_pkg::PRICE_W-1:0]     out_low_price,
  output logic [obp_pkg::PRICE_W-1:0]     out_closing_price,
  output logic [obp_pkg::VOL_W-1:0]       out_bar_volume,
  output logic                            out_last_of_run
);

  logic          cq_push, cq_full, cq_pop, cq_empty;
  obp_pkg::cmd_t cq_in, cq_out;
  obp_pkg::bar_t bar;

  obp_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_mode             (in_mode),
    .in_instrument_index (in_instrument_index),
    .in_tick_time_ns     (in_tick_time_ns),
    .in_mid_price        (in_mid_price),
    .in_tick_volume      (in_tick_volume),
    .q_push              (cq_push),
    .q_data              (cq_in),
    .q_full              (cq_full)
  );

  obp_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cq_push),
    .push_data (cq_in),
    .full      (cq_full),
    .pop       (cq_pop),
    .pop_data  (cq_out),
    .empty     (cq_empty)
  );

  obp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (cq_out),
    .q_empty   (cq_empty),
    .q_pop     (cq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_bar   (bar)
  );

  assign out_bar_instrument    = bar.instrument;
  assign out_bar_start_seconds = bar.start_seconds;
  assign out_open_price        = bar.open_p;
  assign out_high_price        = bar.high_p;
  assign out_low_price         = bar.low_p;
  assign out_closing_price     = bar.close_p;
  assign out_bar_volume        = bar.volume;
  assign out_last_of_run       = bar.last;

endmodule

[design/obp_checker.sv]
// obp_checker: port-level checks for the ohlc bar builder, bound to the top
// level; depends on obp_pkg and tick_to_ohlc_bar_builder
`timescale 1ns / 1ps

module obp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_push,
  input logic                          in_full,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic [obp_pkg::PRICE_W-1:0]   out_open_price,
  input logic [obp_pkg::VOL_W-1:0]     out_bar_volume
);

  // no result word survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // front is still busy in the cycle after it takes a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("input accepted on two consecutive edges");

  // a waiting result word holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_open_price)
      && $stable(out_bar_volume))
    else $error("result word changed while stalled");

endmodule

bind tick_to_ohlc_bar_builder obp_checker u_obp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_push        (in_push),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_open_price (out_open_price),
  .out_bar_volume (out_bar_volume)
);

[verif/tb_tick_to_ohlc_bar_builder.sv]
// testbench for tick_to_ohlc_bar_builder: per-instrument one-minute bar prediction,
// queue-style driver and monitor, idle and stall phases and a long result hold-off
// depends on obp_pkg and the tick_to_ohlc_bar_builder rtl
`timescale 1ns / 1ps

module tb_tick_to_ohlc_bar_builder;
  import obp_pkg::*;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;
  localparam int   HOLD_CYCLES = 2500;
  localparam int   TAIL_CYCLES = 100;

  typedef struct packed {
    logic                mode;
    logic [IDX_W-1:0]    idx;
    logic [TIME_W-1:0]   t_ns;
    logic [PRICE_W-1:0]  price;
    logic [TVOL_W-1:0]   vol;
  } tick_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic                in_mode = MODE_TICK;
  logic [IDX_W-1:0]    in_instrument_index = '0;
  logic [TIME_W-1:0]   in_tick_time_ns = '0;
  logic [PRICE_W-1:0]  in_mid_price = '0;
  logic [TVOL_W-1:0]   in_tick_volume = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [IDX_W-1:0]    out_bar_instrument;
  logic [SEC_W-1:0]    out_bar_start_seconds;
  logic [PRICE_W-1:0]  out_open_price;
  logic [PRICE_W-1:0]  out_high_price;
  logic [PRICE_W-1:0]  out_low_price;
  logic [PRICE_W-1:0]  out_closing_price;
  logic [VOL_W-1:0]    out_bar_volume;
  logic                out_last_of_run;

  tick_to_ohlc_bar_builder u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_mode               (in_mode),
    .in_instrument_index   (in_instrument_index),
    .in_tick_time_ns       (in_tick_time_ns),
    .in_mid_price          (in_mid_price),
    .in_tick_volume        (in_tick_volume),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_bar_instrument    (out_bar_instrument),
    .out_bar_start_seconds (out_bar_start_seconds),
    .out_open_price        (out_open_price),
    .out_high_price        (out_high_price),
    .out_low_price         (out_low_price),
    .out_closing_price     (out_closing_price),
    .out_bar_volume        (out_bar_volume),
    .out_last_of_run       (out_last_of_run)
  );

  // stimulus and expectation stores
  tick_word_t tick_backlog[$];
  bar_t       bars_due[$];

  // predicted bar entries
  logic                bar_open_q [INSTRUMENTS];
  logic [MINUTE_W-1:0] bar_minute [INSTRUMENTS];
  logic [PRICE_W-1:0]  bar_o [INSTRUMENTS];
  logic [PRICE_W-1:0]  bar_h [INSTRUMENTS];
  logic [PRICE_W-1:0]  bar_l [INSTRUMENTS];
  logic [PRICE_W-1:0]  bar_c [INSTRUMENTS];
  logic [VOL_W-1:0]    bar_vol [INSTRUMENTS];

  // stimulus generator history
  logic [TIME_W-1:0]   inst_clock [INSTRUMENTS];
  logic [PRICE_W-1:0]  inst_price [INSTRUMENTS];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_arm = 1'b0;
  int hold_left;
  int fail_count = 0;
  int ticks_taken = 0;
  int flushes_taken = 0;
  int bars_checked = 0;
  int full_run = 0;
  int longest_full = 0;
  tick_word_t word_in_flight;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bar_t closed_bar(input int i, input logic last);
    bar_t b;
    b.instrument    = IDX_W'(i);
    b.start_seconds = {{(SEC_W-MINUTE_W){1'b0}}, bar_minute[i]} * SEC_W'(60);
    b.open_p        = bar_o[i];
    b.high_p        = bar_h[i];
    b.low_p         = bar_l[i];
    b.close_p       = bar_c[i];
    b.volume        = bar_vol[i];
    b.last          = last;
    return b;
  endfunction

  // folds one accepted word into the predicted entries, queues the bars it closes
  task automatic fold_word_into_bars(input tick_word_t w);
    logic [TIME_W-1:0]   q;
    logic [MINUTE_W-1:0] m;
    logic [VOL_W:0]      sum;
    int                  last_i;
    int                  i;
    if (w.mode == MODE_FLUSH) begin
      last_i = -1;
      for (i = 0; i < INSTRUMENTS; i++)
        if (bar_open_q[i]) last_i = i;
      for (i = 0; i < INSTRUMENTS; i++) begin
        if (bar_open_q[i]) begin
          bars_due = {bars_due, closed_bar(i, i == last_i)};
          bar_open_q[i] = 1'b0;
        end
      end
    end else if (int'(w.idx) < INSTRUMENTS) begin
      i = int'(w.idx);
      q = w.t_ns / NS_PER_MINUTE;
      m = q[MINUTE_W-1:0];
      if (!bar_open_q[i] || bar_minute[i] != m) begin
        if (bar_open_q[i]) bars_due = {bars_due, closed_bar(i, 1'b1)};
        bar_minute[i] = m;
        bar_o[i]      = w.price;
        bar_h[i]      = w.price;
        bar_l[i]      = w.price;
        bar_c[i]      = w.price;
        bar_vol[i]    = {{(VOL_W-TVOL_W){1'b0}}, w.vol};
        bar_open_q[i] = 1'b1;
      end else begin
        sum = {1'b0, bar_vol[i]} + {{(VOL_W+1-TVOL_W){1'b0}}, w.vol};
        if (w.price > bar_h[i]) bar_h[i] = w.price;
        if (w.price < bar_l[i]) bar_l[i] = w.price;
        bar_c[i]   = w.price;
        bar_vol[i] = sum[VOL_W] ? VOL_MAX : sum[VOL_W-1:0];
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && in_full) begin
        full_run++;
        if (full_run > longest_full) longest_full = full_run;
      end else begin
        full_run = 0;
      end
      if (in_push && !in_full) begin
        fold_word_into_bars(word_in_flight);
        if (word_in_flight.mode == MODE_FLUSH) flushes_taken++;
        else ticks_taken++;
      end
      if (!in_push || !in_full) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          word_in_flight = tick_backlog.pop_front();
          in_push             <= 1'b1;
          in_mode             <= word_in_flight.mode;
          in_instrument_index <= word_in_flight.idx;
          in_tick_time_ns     <= word_in_flight.t_ns;
          in_mid_price        <= word_in_flight.price;
          in_tick_volume      <= word_in_flight.vol;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    bar_t want;
    bar_t got;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got.instrument    = out_bar_instrument;
        got.start_seconds = out_bar_start_seconds;
        got.open_p        = out_open_price;
        got.high_p        = out_high_price;
        got.low_p         = out_low_price;
        got.close_p       = out_closing_price;
        got.volume        = out_bar_volume;
        got.last          = out_last_of_run;
        if (bars_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: bar with nothing expected: %p", $realtime, got);
        end else begin
          want = bars_due.pop_front();
          bars_checked++;
          if (got.instrument !== want.instrument ||
              got.start_seconds !== want.start_seconds ||
              got.open_p !== want.open_p || got.high_p !== want.high_p ||
              got.low_p !== want.low_p || got.close_p !== want.close_p ||
              got.volume !== want.volume || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: bar mismatch", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      out_pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_word(input logic mode, input int idx, input logic [TIME_W-1:0] t_ns,
                           input logic [PRICE_W-1:0] price, input logic [TVOL_W-1:0] vol);
    tick_word_t w;
    w.mode  = mode;
    w.idx   = IDX_W'(idx);
    w.t_ns  = t_ns;
    w.price = price;
    w.vol   = vol;
    tick_backlog = {tick_backlog, w};
  endtask

  // mostly plausible per-instrument tick streams, with jumps, rewinds and flushes
  task automatic queue_random_ticks(input int n);
    tick_word_t        w;
    logic [TIME_W-1:0] stride;
    int                i;
    int                k;
    int                r;
    for (k = 0; k < n; k++) begin
      w.t_ns  = TIME_W'({$urandom, $urandom});
      w.price = $urandom;
      w.vol   = $urandom;
      if ($urandom_range(11) == 0) begin
        w.mode = MODE_FLUSH;
        w.idx  = IDX_W'($urandom_range(15));
      end else begin
        w.mode = MODE_TICK;
        i = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15);
        w.idx = IDX_W'(i);
        r = $urandom_range(19);
        stride = TIME_W'($urandom_range(25000)) * TIME_W'(1000000);
        if (r == 1) begin
          // rewind, possibly into an earlier minute
          stride = stride * TIME_W'(4);
          w.t_ns = (inst_clock[i] > stride) ? inst_clock[i] - stride : '0;
        end else if (r != 0) begin
          w.t_ns = inst_clock[i] + stride;
        end
        inst_clock[i] = w.t_ns;
        if ($urandom_range(7) != 0)
          w.price = inst_price[i] + PRICE_W'($urandom_range(2000)) - PRICE_W'(1000);
        inst_price[i] = w.price;
        r = $urandom_range(9);
        if (r == 0) w.vol = '0;
        else if (r == 1) w.vol = '1;
      end
      tick_backlog = {tick_backlog, w};
    end
  endtask

  task automatic wait_drained();
    while (tick_backlog.size() != 0 || in_push || bars_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_ticks(n);
    wait_drained();
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    int i;
    for (i = 0; i < INSTRUMENTS; i++) begin
      bar_open_q[i] = 1'b0;
      inst_clock[i] = TIME_W'({$urandom, $urandom}) >> 3;
      inst_price[i] = $urandom;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    push_word(MODE_FLUSH, 9, '1, '1, '1);
    push_word(MODE_TICK, 0, '0, '0, '0);
    push_word(MODE_TICK, 0, TIME_W'(64'd59999999999), '1, '1);
    push_word(MODE_TICK, 0, TIME_W'(64'd1000), 32'd5, 32'd7);
    push_word(MODE_TICK, 15, '1, '1, '1);
    push_word(MODE_TICK, 15, '1 - TIME_W'(1000), '0, '1);
    push_word(MODE_TICK, 0, TIME_W'(64'd60000000000), 32'd100, 32'd1);
    push_word(MODE_TICK, 0, TIME_W'(64'd59999999999), 32'd200, 32'd2);
    push_word(MODE_TICK, 7, TIME_W'(64'h2aaa_aaaa_aaaa_aaaa), 32'h5555_5555, 32'haaaa_aaaa);
    push_word(MODE_TICK, 7, TIME_W'(64'h2aaa_aaaa_aaaa_aaab), 32'haaaa_aaaa, 32'h5555_5555);
    push_word(MODE_FLUSH, 0, '0, '0, '0);
    push_word(MODE_FLUSH, 15, '1, '1, '1);
    push_word(MODE_TICK, 3, TIME_W'(64'h5555_5555_5555_5555), 32'd42, 32'd3);
    push_word(MODE_TICK, 3, TIME_W'(64'h5555_5555_5555_5555) - TIME_W'(64'd120000000000),
              32'd43, 32'd4);
    push_word(MODE_FLUSH, 3, TIME_W'(64'h1234_5678_9abc_def0), 32'hffff_0000, 32'h0000_ffff);
    wait_drained();

    run_phase(0, 0, 20);
    run_phase(72, 0, 20);
    run_phase(0, 72, 20);
    run_phase(25, 25, 20);

    // result side held off while the sender keeps going: open all bars, roll them
    // to the next minute, then flush
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_arm = 1'b1;
    t0 = TIME_W'({$urandom, $urandom}) >> 4;
    for (i = 0; i < INSTRUMENTS; i++)
      push_word(MODE_TICK, i, t0, $urandom, $urandom);
    for (i = 0; i < INSTRUMENTS; i++)
      push_word(MODE_TICK, i, t0 + TIME_W'(64'd60000000000), $urandom, $urandom);
    push_word(MODE_FLUSH, $urandom_range(15), '0, '0, '0);
    @(negedge clk);
    hold_arm = 1'b0;
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (bars_due.size() != 0) fail_count += bars_due.size();
    $display("covered %0d ticks and %0d flushes, %0d bars checked", ticks_taken,
             flushes_taken, bars_checked);
    $display("longest input stall %0d cycles, %0d failures", longest_full, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/obp_pkg.sv
design/obp_front.sv
design/obp_cmdq.sv
design/obp_back.sv
design/tick_to_ohlc_bar_builder.sv
design/obp_checker.sv
verif/tb_tick_to_ohlc_bar_builder.sv
